// ===== design/brct_pkg.sv =====
`default_nettype none

package brct_pkg;

    localparam int BYTE_W      = 8;
    localparam int SIZE_W      = 4;
    localparam int ENTRY_W     = 3;
    localparam int NUM_ENTRIES = 8;
    localparam int PERM_W      = ENTRY_W * NUM_ENTRIES;
    localparam int FILL_W      = 7;
    localparam int LFSR_W      = 16;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_COLS         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COL_PERM     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_PERM     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DECRYPT_MODE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PAD_SEED     = 3'd5;

    localparam logic [SIZE_W-1:0] COLS_RESET     = 4'd8;
    localparam logic [SIZE_W-1:0] ROWS_RESET     = 4'd8;
    localparam logic [PERM_W-1:0] PERM_RESET     = 24'd16434824;
    localparam logic [LFSR_W-1:0] PAD_SEED_RESET = 16'd44257;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [BYTE_W-1:0] LETTER_A  = 8'd97;
    localparam logic [BYTE_W-1:0] LETTER_Z  = 8'd122;
    localparam int ALPHA_N = int'(LETTER_Z) - int'(LETTER_A) + 1;
    // floor(2^16 / 26): quotient estimate is exact or one low
    localparam int RECIP_W = 12;
    localparam int RECIP   = (1 << LFSR_W) / ALPHA_N;
    localparam int PROD_W  = LFSR_W + RECIP_W;
    localparam int REM_W   = 6;

    typedef struct packed {
        logic write_byte;
        logic hold_load;
        logic emit_start;
        logic issue;
        logic emit_done;
        logic pad_step;
        logic pad_write;
        logic drop_push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic decrypt;
        logic can_issue;
        logic issue_last;
        logic pad_last;
    } dp_status_t;

    function automatic logic [ENTRY_W-1:0] perm_entry(input logic [PERM_W-1:0] tbl,
                                                      input logic [ENTRY_W-1:0] idx);
        return tbl[idx*ENTRY_W +: ENTRY_W];
    endfunction

    function automatic logic is_perm(input logic [PERM_W-1:0] tbl,
                                     input logic [SIZE_W-1:0] n);
        logic [NUM_ENTRIES-1:0] seen;
        logic                   ok;
        logic [ENTRY_W-1:0]     e;
        seen = '0;
        ok   = 1'b1;
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            e = tbl[k*ENTRY_W +: ENTRY_W];
            if (SIZE_W'(k) < n) begin
                if ({1'b0, e} >= n || seen[e]) begin
                    ok = 1'b0;
                end
                seen[e] = 1'b1;
            end
        end
        return ok;
    endfunction

    // entry c of the result is the index j whose entry equals c
    function automatic logic [PERM_W-1:0] invert(input logic [PERM_W-1:0] tbl,
                                                 input logic [SIZE_W-1:0] n);
        logic [PERM_W-1:0] inv;
        inv = '0;
        for (int c = 0; c < NUM_ENTRIES; c++) begin
            for (int j = 0; j < NUM_ENTRIES; j++) begin
                if (SIZE_W'(j) < n && tbl[j*ENTRY_W +: ENTRY_W] == ENTRY_W'(c)) begin
                    inv[c*ENTRY_W +: ENTRY_W] = ENTRY_W'(j);
                end
            end
        end
        return inv;
    endfunction

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        return (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
    endfunction

endpackage

`default_nettype wire

// ===== design/brct_ram.sv =====
`default_nettype none

module brct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read and a write of one address return the old data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/brct_ctrl.sv =====
`default_nettype none

module brct_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_kind,
    output logic                       s_ready,
    input  wire brct_pkg::dp_status_t  status,
    output brct_pkg::ctrl_cmd_t        cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_EMIT      = 3'd1;
    localparam logic [2:0] ST_PAD_STEP  = 3'd2;
    localparam logic [2:0] ST_PAD_WRITE = 3'd3;
    localparam logic [2:0] ST_DROP      = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (status.full) begin
                        // the pending block goes out before this item takes effect
                        cmd.hold_load  = 1'b1;
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT;
                    end else if (s_kind == brct_pkg::KIND_BYTE) begin
                        cmd.write_byte = 1'b1;
                    end else if (!status.empty) begin
                        if (status.decrypt) begin
                            state_next = ST_DROP;
                        end else begin
                            cmd.hold_load = 1'b1;
                            state_next    = ST_PAD_STEP;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (status.can_issue) begin
                    cmd.issue = 1'b1;
                    if (status.issue_last) begin
                        cmd.emit_done = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_PAD_STEP: begin
                cmd.pad_step = 1'b1;
                state_next   = ST_PAD_WRITE;
            end
            ST_PAD_WRITE: begin
                cmd.pad_write = 1'b1;
                if (status.pad_last) begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT;
                end else begin
                    state_next = ST_PAD_STEP;
                end
            end
            ST_DROP: begin
                if (status.can_issue) begin
                    cmd.drop_push = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/brct_datapath.sv =====
`default_nettype none

module brct_datapath #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [brct_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [brct_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  wire logic                                   s_kind,
    input  wire logic [brct_pkg::BYTE_W-1:0]            s_data_byte,
    input  wire brct_pkg::ctrl_cmd_t                    cmd,
    output brct_pkg::dp_status_t                        status,
    output logic                                        ram_we,
    output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] ram_waddr,
    output logic [brct_pkg::BYTE_W-1:0]                 ram_wdata,
    output logic                                        ram_re,
    output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] ram_raddr,
    input  wire logic [brct_pkg::BYTE_W-1:0]            ram_rdata,
    input  wire logic                                   m_ready,
    output logic                                        m_valid,
    output logic [brct_pkg::BYTE_W-1:0]                 m_out_byte,
    output logic                                        m_block_last,
    output logic                                        m_message_last,
    output logic                                        m_tail_dropped,
    output logic                                        m_key_error
);

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SIZE_W  = brct_pkg::SIZE_W;
    localparam int ENTRY_W = brct_pkg::ENTRY_W;
    localparam int PERM_W  = brct_pkg::PERM_W;
    localparam int FILL_W  = brct_pkg::FILL_W;
    localparam int LFSR_W  = brct_pkg::LFSR_W;
    localparam int BYTE_W  = brct_pkg::BYTE_W;
    localparam int PROD_W  = brct_pkg::PROD_W;
    localparam int REM_W   = brct_pkg::REM_W;

    localparam logic [SIZE_W-1:0] MAX_COLS_C = SIZE_W'(MAX_COLS);
    localparam logic [SIZE_W-1:0] MAX_ROWS_C = SIZE_W'(MAX_ROWS);
    localparam logic [PROD_W-1:0] RECIP_C    = PROD_W'(brct_pkg::RECIP);
    localparam logic [LFSR_W-1:0] ALPHA_C    = LFSR_W'(brct_pkg::ALPHA_N);
    localparam logic [REM_W-1:0]  ALPHA_R    = REM_W'(brct_pkg::ALPHA_N);

    // configuration
    logic [SIZE_W-1:0] cols_reg;
    logic [SIZE_W-1:0] rows_reg;
    logic [PERM_W-1:0] col_perm_reg;
    logic [PERM_W-1:0] row_perm_reg;
    logic              decrypt_reg;
    logic [LFSR_W-1:0] lfsr_reg;

    // derived from configuration
    logic [SIZE_W-1:0] nc;
    logic [SIZE_W-1:0] nr;
    logic [FILL_W-1:0] bsize;
    logic              key_bad_reg;
    logic [PERM_W-1:0] col_inv_reg;
    logic [PERM_W-1:0] row_inv_reg;

    // fill and emission
    logic [FILL_W-1:0]  fill_reg;
    logic [ENTRY_W-1:0] row_cnt_reg;
    logic [ENTRY_W-1:0] col_cnt_reg;
    logic               hold_kind_reg;
    logic [BYTE_W-1:0]  hold_byte_reg;
    logic               msg_last_reg;
    logic               col_last;
    logic               row_last;
    logic [ENTRY_W-1:0] src_row;
    logic [ENTRY_W-1:0] src_col;
    logic [FILL_W-1:0]  src_addr;

    // pad letter
    logic [LFSR_W-1:0]  lfsr_nxt;
    logic [PROD_W-1:0]  prod_reg;
    logic [LFSR_W-1:0]  quot_x26;
    logic [LFSR_W-1:0]  rem_full;
    logic [REM_W-1:0]   rem_raw;
    logic [REM_W-1:0]   rem_fix;
    logic [BYTE_W-1:0]  letter;

    // read stage and output register
    logic               rd_valid_reg;
    logic               rd_blast_reg;
    logic               rd_mlast_reg;
    logic               rd_drop_reg;
    logic               rd_kerr_reg;
    logic               out_load;
    logic               st1_adv;
    logic               push;
    logic               m_valid_reg;
    logic [BYTE_W-1:0]  m_out_byte_reg;
    logic               m_block_last_reg;
    logic               m_message_last_reg;
    logic               m_tail_dropped_reg;
    logic               m_key_error_reg;

    always_comb begin
        if (cols_reg == '0) begin
            nc = SIZE_W'(1);
        end else if (cols_reg > MAX_COLS_C) begin
            nc = MAX_COLS_C;
        end else begin
            nc = cols_reg;
        end
        if (rows_reg == '0) begin
            nr = SIZE_W'(1);
        end else if (rows_reg > MAX_ROWS_C) begin
            nr = MAX_ROWS_C;
        end else begin
            nr = rows_reg;
        end
    end

    assign bsize = FILL_W'(nc) * FILL_W'(nr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg     <= brct_pkg::COLS_RESET;
            rows_reg     <= brct_pkg::ROWS_RESET;
            col_perm_reg <= brct_pkg::PERM_RESET;
            row_perm_reg <= brct_pkg::PERM_RESET;
            decrypt_reg  <= 1'b0;
            lfsr_reg     <= brct_pkg::PAD_SEED_RESET;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    brct_pkg::REG_COLS:         cols_reg     <= cfg_wdata[SIZE_W-1:0];
                    brct_pkg::REG_ROWS:         rows_reg     <= cfg_wdata[SIZE_W-1:0];
                    brct_pkg::REG_COL_PERM:     col_perm_reg <= cfg_wdata[PERM_W-1:0];
                    brct_pkg::REG_ROW_PERM:     row_perm_reg <= cfg_wdata[PERM_W-1:0];
                    brct_pkg::REG_DECRYPT_MODE: decrypt_reg  <= cfg_wdata[0];
                    brct_pkg::REG_PAD_SEED: begin
                        // a zero seed would lock the LFSR
                        lfsr_reg <= (cfg_wdata[LFSR_W-1:0] == '0) ? LFSR_W'(1)
                                                                  : cfg_wdata[LFSR_W-1:0];
                    end
                    default: ;
                endcase
            end else if (cmd.pad_step) begin
                lfsr_reg <= lfsr_nxt;
            end
        end
    end

    // key checks and inverse tables are registered from the configuration registers
    always_ff @(posedge aclk) begin
        key_bad_reg <= !brct_pkg::is_perm(col_perm_reg, nc) ||
                       !brct_pkg::is_perm(row_perm_reg, nr);
        col_inv_reg <= brct_pkg::invert(col_perm_reg, nc);
        row_inv_reg <= brct_pkg::invert(row_perm_reg, nr);
    end

    // source of output position (row_cnt, col_cnt)
    always_comb begin
        if (key_bad_reg) begin
            src_row = row_cnt_reg;
            src_col = col_cnt_reg;
        end else if (decrypt_reg) begin
            src_row = brct_pkg::perm_entry(row_perm_reg, row_cnt_reg);
            src_col = brct_pkg::perm_entry(col_perm_reg, col_cnt_reg);
        end else begin
            src_row = brct_pkg::perm_entry(row_inv_reg, row_cnt_reg);
            src_col = brct_pkg::perm_entry(col_inv_reg, col_cnt_reg);
        end
    end

    assign src_addr = FILL_W'(src_row) * FILL_W'(nc) + FILL_W'(src_col);
    assign col_last = ({1'b0, col_cnt_reg} == nc - SIZE_W'(1));
    assign row_last = ({1'b0, row_cnt_reg} == nr - SIZE_W'(1));

    always_ff @(posedge aclk) begin
        if (cmd.emit_start) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end else if (cmd.issue) begin
            if (col_last) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= row_cnt_reg + ENTRY_W'(1);
            end else begin
                col_cnt_reg <= col_cnt_reg + ENTRY_W'(1);
            end
        end
        if (cmd.hold_load) begin
            hold_kind_reg <= s_kind;
            hold_byte_reg <= s_data_byte;
            msg_last_reg  <= (s_kind == brct_pkg::KIND_END);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.write_byte || cmd.pad_write) begin
            fill_reg <= fill_reg + FILL_W'(1);
        end else if (cmd.emit_done) begin
            fill_reg <= (hold_kind_reg == brct_pkg::KIND_BYTE) ? FILL_W'(1) : '0;
        end else if (cmd.drop_push) begin
            fill_reg <= '0;
        end
    end

    // pad letter: 97 + lfsr mod 26 by reciprocal multiply and one correction
    assign lfsr_nxt = brct_pkg::lfsr_step(lfsr_reg);

    always_ff @(posedge aclk) begin
        if (cmd.pad_step) begin
            prod_reg <= PROD_W'(lfsr_nxt) * RECIP_C;
        end
    end

    assign quot_x26 = LFSR_W'(prod_reg[PROD_W-1:LFSR_W]) * ALPHA_C;
    assign rem_full = lfsr_reg - quot_x26;
    assign rem_raw  = rem_full[REM_W-1:0];
    assign rem_fix  = (rem_raw >= ALPHA_R) ? rem_raw - ALPHA_R : rem_raw;
    assign letter   = brct_pkg::LETTER_A + BYTE_W'(rem_fix);

    // block store write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = fill_reg[ADDR_W-1:0];
        ram_wdata = s_data_byte;
        if (cmd.write_byte) begin
            ram_we = 1'b1;
        end else if (cmd.pad_write) begin
            ram_we    = 1'b1;
            ram_wdata = letter;
        end else if (cmd.emit_done && hold_kind_reg == brct_pkg::KIND_BYTE) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = hold_byte_reg;
        end
    end

    assign ram_re    = cmd.issue;
    assign ram_raddr = src_addr[ADDR_W-1:0];

    // read stage lines up with the registered RAM data, then the output register
    assign out_load = rd_valid_reg && (!m_valid_reg || m_ready);
    assign st1_adv  = !rd_valid_reg || out_load;
    assign push     = cmd.issue || cmd.drop_push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (st1_adv) begin
                rd_valid_reg <= push;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            rd_blast_reg <= cmd.issue && row_last && col_last;
            rd_mlast_reg <= cmd.drop_push || (row_last && col_last && msg_last_reg);
            rd_drop_reg  <= cmd.drop_push;
            rd_kerr_reg  <= key_bad_reg;
        end
        if (out_load) begin
            m_out_byte_reg     <= rd_drop_reg ? '0 : ram_rdata;
            m_block_last_reg   <= rd_blast_reg;
            m_message_last_reg <= rd_mlast_reg;
            m_tail_dropped_reg <= rd_drop_reg;
            m_key_error_reg    <= rd_kerr_reg;
        end
    end

    assign status.full       = (fill_reg >= bsize);
    assign status.empty      = (fill_reg == '0);
    assign status.decrypt    = decrypt_reg;
    assign status.can_issue  = st1_adv;
    assign status.issue_last = row_last && col_last;
    assign status.pad_last   = (fill_reg + FILL_W'(1) == bsize);

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_out_byte_reg;
    assign m_block_last   = m_block_last_reg;
    assign m_message_last = m_message_last_reg;
    assign m_tail_dropped = m_tail_dropped_reg;
    assign m_key_error    = m_key_error_reg;

endmodule

`default_nettype wire

// ===== design/block_row_column_transposition.sv =====
`default_nettype none

// Row/column transposition of a byte stream in blocks of rows*cols bytes.
// Message bytes are taken one per cycle while a block fills and are written
// into a single-port-read block store. A full block is held until the next
// item arrives; that item is taken at once and the block is then read out of
// the store one byte per cycle unless the output stalls, so input is held off
// until the block is out (the store's one read port sets this). An end of
// message after a partial encrypt block first writes pad letters, each by an
// LFSR step and reciprocal mod-26 multiply, then the store write, then emits
// the block; a partial decrypt block yields one flag result. Results pass
// through a read stage and an output register, so a stalled m_ready backs up
// at most two bytes before the read sequence waits.

module block_row_column_transposition #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [brct_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [brct_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_kind,
    input  wire logic [brct_pkg::BYTE_W-1:0]        s_data_byte,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [brct_pkg::BYTE_W-1:0]             m_out_byte,
    output logic                                    m_block_last,
    output logic                                    m_message_last,
    output logic                                    m_tail_dropped,
    output logic                                    m_key_error
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    brct_pkg::ctrl_cmd_t  cmd;
    brct_pkg::dp_status_t status;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [brct_pkg::BYTE_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [brct_pkg::BYTE_W-1:0] ram_rdata;

    brct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    brct_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_kind         (s_kind),
        .s_data_byte    (s_data_byte),
        .cmd            (cmd),
        .status         (status),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_out_byte     (m_out_byte),
        .m_block_last   (m_block_last),
        .m_message_last (m_message_last),
        .m_tail_dropped (m_tail_dropped),
        .m_key_error    (m_key_error)
    );

    brct_ram #(
        .WIDTH (brct_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_block_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== design/brct_checker.sv =====
`default_nettype none

module brct_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [brct_pkg::BYTE_W-1:0] m_out_byte,
    input wire logic                        m_block_last,
    input wire logic                        m_message_last,
    input wire logic                        m_tail_dropped,
    input wire logic                        m_key_error
);

    // a stalled transfer holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_block_last) &&
            $stable(m_message_last) && $stable(m_tail_dropped) && $stable(m_key_error))
        else $error("result changed while stalled");

    // a dropped tail is a lone flag transfer closing the message
    a_drop_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tail_dropped |-> m_message_last && !m_block_last && m_out_byte == '0)
        else $error("malformed dropped-tail result");

    // a message ends either on a block boundary or with a dropped tail
    a_msg_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_message_last |-> m_block_last || m_tail_dropped)
        else $error("message end without block end");

endmodule

bind block_row_column_transposition brct_checker u_brct_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_byte     (m_out_byte),
    .m_block_last   (m_block_last),
    .m_message_last (m_message_last),
    .m_tail_dropped (m_tail_dropped),
    .m_key_error    (m_key_error)
);

`default_nettype wire
